>>> rtl/core/rcsh_pkg.sv
`default_nettype none
package rcsh_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 24;

    typedef enum logic [2:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_DIR_X       = 3'd2,
        CFG_DIR_Y       = 3'd3,
        CFG_RAY_LENGTH  = 3'd4,
        CFG_INTERPOLATE = 3'd5
    } t_cfg_idx;

    localparam logic OP_CIRCLE  = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

endpackage
`default_nettype wire

>>> rtl/core/ray_circle_segment_hit_test.sv
// Channel  Direction  Transfer content
// s_axis   in         item: tdata first/second points and radius, tuser op
// m_axis   out        result: hit, point_x, point_y, length_now
// cfg      in         register write: index and data, no handshake
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// The ray end point is computed first. A circle then takes up to one square-root
// pass for the hit test, and a second pass when a hit with interpolation on
// shortens the length. A segment takes up to two multiply-divide passes.
// A single multiplier carries all products outside the multiply-divide unit.
// Reset is synchronous and active low.
`default_nettype none
module ray_circle_segment_hit_test import rcsh_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // first_x, first_y, second_x, second_y, radius
    input  wire logic [((5*COORD_WIDTH+6)/8)*8-1:0]     s_axis_tdata,
    // op
    input  wire logic                                   s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // hit, point_x, point_y, length_now
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [2:0]                             i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                 i_cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int LW  = W - 1;
    localparam int DW  = W + 1;
    localparam int MW  = W + 2;
    localparam int PW  = 2 * MW;
    localparam int SW  = 2 * DW;
    localparam int ODW = ((3 * W + 7) / 8) * 8;
    localparam logic signed [PW-1:0] CMAX = PW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [PW-1:0] CMIN = -CMAX - PW'(1);
    localparam logic signed [MW-1:0] LMAX = MW'((64'd1 << LW) - 64'd1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_EX, ST_EY, ST_EEND,
        ST_CBOX, ST_CM2, ST_CM3, ST_CM4, ST_CM5, ST_CM6, ST_CSQ, ST_CRD, ST_CCMP,
        ST_LM1, ST_LM2, ST_LM3, ST_LM4, ST_LSQ,
        ST_SM1, ST_SM2, ST_SM3, ST_SM4, ST_SM5, ST_SM6, ST_SM7,
        ST_SNORM, ST_SCHK, ST_SDX, ST_SDY, ST_DONE
    } t_state;

    t_state r_state;

    logic signed [W-1:0]  r_start_x, r_start_y, r_dir_x, r_dir_y;
    logic                 r_interp;
    logic [LW-1:0]        r_wlen;

    logic                 r_op;
    logic signed [W-1:0]  r_fx, r_fy, r_gx, r_gy;
    logic [LW-1:0]        r_rad;
    logic signed [W-1:0]  r_ex, r_ey;
    logic signed [PW-1:0] r_acc, r_den, r_na, r_nb;
    logic [SW-1:0]        r_sq;
    logic [DW-1:0]        r_d;
    logic                 r_hit;
    logic signed [W-1:0]  r_px, r_py;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic signed [W-1:0]  r_out_px, r_out_py;
    logic [LW-1:0]        r_out_len;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_p;

    logic                 w_sq_start, w_md_start;
    t_unit_ctl            w_sq_ctl, w_md_ctl;
    logic [DW-1:0]        w_root;
    logic [DW-1:0]        w_quot;
    logic [DW-1:0]        w_md_mult;

    function automatic logic signed [MW-1:0] sx2m(input logic signed [W-1:0] v);
        return MW'(v);
    endfunction

    function automatic logic signed [W-1:0] sat_coord(input logic signed [PW-1:0] v);
        if (v > CMAX) begin
            return W'(CMAX);
        end else if (v < CMIN) begin
            return W'(CMIN);
        end
        return W'(v);
    endfunction

    logic signed [DW-1:0] w_ax, w_ay, w_cyey, w_cxex, w_dxc, w_dyc;
    logic signed [DW-1:0] w_dx21, w_dy21, w_dx43, w_dy43, w_dx13, w_dy13;
    logic signed [MW-1:0] w_rad_m;
    logic signed [MW-1:0] w_cxlo, w_cxhi, w_cylo, w_cyhi;
    logic                 w_reject;
    logic signed [PW-1:0] w_end;
    logic signed [PW-1:0] w_abs_acc;
    logic signed [MW-1:0] w_dist;
    logic [DW-1:0]        w_adx, w_ady;
    logic signed [PW-1:0] w_pnt;

    assign w_ax   = DW'(r_start_x) - DW'(r_ex);
    assign w_ay   = DW'(r_start_y) - DW'(r_ey);
    assign w_cyey = DW'(r_fy) - DW'(r_ey);
    assign w_cxex = DW'(r_fx) - DW'(r_ex);
    assign w_dxc  = DW'(r_fx) - DW'(r_start_x);
    assign w_dyc  = DW'(r_fy) - DW'(r_start_y);
    assign w_dx21 = DW'(r_ex) - DW'(r_start_x);
    assign w_dy21 = DW'(r_ey) - DW'(r_start_y);
    assign w_dx43 = DW'(r_gx) - DW'(r_fx);
    assign w_dy43 = DW'(r_gy) - DW'(r_fy);
    assign w_dx13 = DW'(r_start_x) - DW'(r_fx);
    assign w_dy13 = DW'(r_start_y) - DW'(r_fy);
    assign w_adx  = w_dx21[DW-1] ? DW'(-w_dx21) : DW'(w_dx21);
    assign w_ady  = w_dy21[DW-1] ? DW'(-w_dy21) : DW'(w_dy21);

    assign w_rad_m = $signed({2'b00, r_rad}) ;
    assign w_cxlo  = sx2m(r_fx) - w_rad_m;
    assign w_cxhi  = sx2m(r_fx) + w_rad_m;
    assign w_cylo  = sx2m(r_fy) - w_rad_m;
    assign w_cyhi  = sx2m(r_fy) + w_rad_m;
    assign w_reject =
        (sx2m(r_start_x) < w_cxlo && sx2m(r_ex) < w_cxlo) ||
        (sx2m(r_start_x) > w_cxhi && sx2m(r_ex) > w_cxhi) ||
        (sx2m(r_start_y) < w_cylo && sx2m(r_ey) < w_cylo) ||
        (sx2m(r_start_y) > w_cyhi && sx2m(r_ey) > w_cyhi);

    assign w_abs_acc = r_acc[PW-1] ? -r_acc : r_acc;
    assign w_dist    = $signed({1'b0, w_root}) - w_rad_m;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_EX:   begin w_ma = -sx2m(r_dir_x); w_mb = $signed({3'b000, r_wlen}); end
            ST_EY:   begin w_ma = -sx2m(r_dir_y); w_mb = $signed({3'b000, r_wlen}); end
            ST_CBOX: begin w_ma = MW'(w_ax);   w_mb = MW'(w_cyey); end
            ST_CM2:  begin w_ma = MW'(w_cxex); w_mb = MW'(w_ay);   end
            ST_CM3:  begin w_ma = MW'(w_ax);   w_mb = MW'(w_ax);   end
            ST_CM4:  begin w_ma = MW'(w_ay);   w_mb = MW'(w_ay);   end
            ST_CRD:  begin w_ma = w_rad_m;     w_mb = $signed({1'b0, r_d}); end
            ST_LM1:  begin w_ma = MW'(w_dxc);  w_mb = MW'(w_dxc);  end
            ST_LM2:  begin w_ma = MW'(w_dyc);  w_mb = MW'(w_dyc);  end
            ST_SM1:  begin w_ma = MW'(w_dy43); w_mb = MW'(w_dx21); end
            ST_SM2:  begin w_ma = MW'(w_dx43); w_mb = MW'(w_dy21); end
            ST_SM3:  begin w_ma = MW'(w_dx43); w_mb = MW'(w_dy13); end
            ST_SM4:  begin w_ma = MW'(w_dy43); w_mb = MW'(w_dx13); end
            ST_SM5:  begin w_ma = MW'(w_dx21); w_mb = MW'(w_dy13); end
            ST_SM6:  begin w_ma = MW'(w_dy21); w_mb = MW'(w_dx13); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    rcsh_mul #(.MW(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign w_sq_start = (r_state == ST_CM6) || (r_state == ST_LM4);

    rcsh_sqrt #(.IW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (r_sq),
        .o_ctl   (w_sq_ctl),
        .o_root  (w_root)
    );

    assign w_md_start = (r_state == ST_SCHK && !r_na[PW-1] && !r_nb[PW-1] &&
                         r_na <= r_den && r_nb <= r_den) ||
                        (r_state == ST_SDX && w_md_ctl.done);
    assign w_md_mult  = (r_state == ST_SCHK) ? w_adx : w_ady;

    rcsh_muldiv #(.NW(PW), .MBW(DW)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_num   (r_na),
        .i_den   (r_den),
        .i_mult  (w_md_mult),
        .o_ctl   (w_md_ctl),
        .o_quot  (w_quot)
    );

    assign w_end = PW'(r_start_x) + (w_p >>> FRAC_BITS);
    assign w_pnt = (r_state == ST_SDX) ?
        (w_dx21[DW-1] ? PW'(r_start_x) - PW'(w_quot) : PW'(r_start_x) + PW'(w_quot)) :
        (w_dy21[DW-1] ? PW'(r_start_y) - PW'(w_quot) : PW'(r_start_y) + PW'(w_quot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_interp    <= 1'b1;
            r_wlen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START_X:     r_start_x <= i_cfg_data;
                    CFG_START_Y:     r_start_y <= i_cfg_data;
                    CFG_DIR_X:       r_dir_x   <= i_cfg_data;
                    CFG_DIR_Y:       r_dir_y   <= i_cfg_data;
                    CFG_RAY_LENGTH:  r_wlen    <= i_cfg_data[LW-1:0];
                    CFG_INTERPOLATE: r_interp  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_fx    <= s_axis_tdata[0 +: W];
                        r_fy    <= s_axis_tdata[W +: W];
                        r_gx    <= s_axis_tdata[2*W +: W];
                        r_gy    <= s_axis_tdata[3*W +: W];
                        r_rad   <= s_axis_tdata[4*W +: LW];
                        r_hit   <= 1'b0;
                        r_px    <= '0;
                        r_py    <= '0;
                        r_state <= ST_EX;
                    end
                end
                ST_EX: r_state <= ST_EY;
                ST_EY: begin
                    r_ex    <= sat_coord(w_end);
                    r_state <= ST_EEND;
                end
                ST_EEND: begin
                    r_ey    <= sat_coord(PW'(r_start_y) + (w_p >>> FRAC_BITS));
                    r_state <= (r_op == OP_CIRCLE) ? ST_CBOX : ST_SM1;
                end
                ST_CBOX: begin
                    if (w_reject) begin
                        r_state <= ST_DONE;
                    end else if (w_ax == '0 && w_ay == '0) begin
                        r_hit   <= 1'b1;
                        r_state <= r_interp ? ST_LM1 : ST_DONE;
                    end else begin
                        r_state <= ST_CM2;
                    end
                end
                ST_CM2: begin r_acc <= w_p;         r_state <= ST_CM3; end
                ST_CM3: begin r_acc <= r_acc - w_p; r_state <= ST_CM4; end
                ST_CM4: begin r_sq <= w_p[SW-1:0];  r_state <= ST_CM5; end
                ST_CM5: begin r_sq <= r_sq + w_p[SW-1:0]; r_state <= ST_CM6; end
                ST_CM6: r_state <= ST_CSQ;
                ST_CSQ: begin
                    if (w_sq_ctl.done) begin
                        r_d     <= w_root;
                        r_state <= ST_CRD;
                    end
                end
                ST_CRD: r_state <= ST_CCMP;
                ST_CCMP: begin
                    if (w_abs_acc < w_p) begin
                        r_hit   <= 1'b1;
                        r_state <= r_interp ? ST_LM1 : ST_DONE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_LM1: r_state <= ST_LM2;
                ST_LM2: begin r_sq <= w_p[SW-1:0]; r_state <= ST_LM3; end
                ST_LM3: begin r_sq <= r_sq + w_p[SW-1:0]; r_state <= ST_LM4; end
                ST_LM4: r_state <= ST_LSQ;
                ST_LSQ: begin
                    if (w_sq_ctl.done) begin
                        if (w_dist[MW-1]) begin
                            r_wlen <= '0;
                        end else if (w_dist > LMAX) begin
                            r_wlen <= LW'(LMAX);
                        end else begin
                            r_wlen <= LW'(w_dist);
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_SM1: r_state <= ST_SM2;
                ST_SM2: begin r_acc <= w_p;         r_state <= ST_SM3; end
                ST_SM3: begin r_den <= r_acc - w_p; r_state <= ST_SM4; end
                ST_SM4: begin r_acc <= w_p;         r_state <= ST_SM5; end
                ST_SM5: begin r_na  <= r_acc - w_p; r_state <= ST_SM6; end
                ST_SM6: begin r_acc <= w_p;         r_state <= ST_SM7; end
                ST_SM7: begin r_nb  <= r_acc - w_p; r_state <= ST_SNORM; end
                ST_SNORM: begin
                    if (r_den == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        if (r_den[PW-1]) begin
                            r_den <= -r_den;
                            r_na  <= -r_na;
                            r_nb  <= -r_nb;
                        end
                        r_state <= ST_SCHK;
                    end
                end
                ST_SCHK: r_state <= w_md_start ? ST_SDX : ST_DONE;
                ST_SDX: begin
                    if (w_md_ctl.done) begin
                        r_px    <= sat_coord(w_pnt);
                        r_state <= ST_SDY;
                    end
                end
                ST_SDY: begin
                    if (w_md_ctl.done) begin
                        r_py    <= sat_coord(w_pnt);
                        r_hit   <= 1'b1;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_px    <= r_px;
                        r_out_py    <= r_py;
                        r_out_len   <= r_wlen;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODW'({r_out_len, r_out_py, r_out_px, r_out_hit});

    a_miss_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_px == '0 && r_out_py == '0)
        else $error("point reported without a hit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

>>> rtl/core/rcsh_mul.sv
`default_nettype none
module rcsh_mul #(
    parameter int MW = 26
) (
    input  wire logic                   i_clk,
    input  wire logic signed [MW-1:0]   i_a,
    input  wire logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0]      o_p
);

    logic signed [2*MW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> rtl/core/rcsh_sqrt.sv
`default_nettype none
module rcsh_sqrt import rcsh_pkg::*; #(
    parameter int IW = 50
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [IW-1:0]     i_value,
    output t_unit_ctl              o_ctl,
    output logic [IW/2-1:0]        o_root
);

    localparam int RW = IW / 2;
    localparam int EW = RW + 3;
    localparam int CW = $clog2(RW + 1);

    logic [IW-1:0] r_rad;
    logic [EW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [EW-1:0] w_shift;
    logic [EW-1:0] w_trial;

    assign w_shift = {r_rem[EW-3:0], r_rad[IW-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rad  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[IW-3:0], 2'b00};
            if (w_shift >= w_trial) begin
                r_rem  <= w_shift - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_root = r_root;

endmodule
`default_nettype wire

>>> rtl/core/rcsh_muldiv.sv
`default_nettype none
module rcsh_muldiv import rcsh_pkg::*; #(
    parameter int NW = 52,
    parameter int MBW = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NW-1:0]     i_num,
    input  wire logic [NW-1:0]     i_den,
    input  wire logic [MBW-1:0]    i_mult,
    output t_unit_ctl              o_ctl,
    output logic [MBW-1:0]         o_quot
);

    // Computes floor(num * mult / den) one multiplier bit per cycle, for num <= den.
    localparam int CW = $clog2(MBW + 1);

    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_den;
    logic [MBW-1:0] r_mult;
    logic [NW-1:0]  r_rem;
    logic [MBW-1:0] r_quot;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [NW-1:0]  w_t;
    logic [NW-1:0]  w_den2;

    assign w_t    = {r_rem[NW-2:0], 1'b0} + (r_mult[MBW-1] ? r_num : '0);
    assign w_den2 = {r_den[NW-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MBW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_mult <= i_mult;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_mult <= {r_mult[MBW-2:0], 1'b0};
            if (w_t >= w_den2) begin
                r_rem  <= w_t - w_den2;
                r_quot <= {r_quot[MBW-2:0], 1'b0} + MBW'(2);
            end else if (w_t >= r_den) begin
                r_rem  <= w_t - r_den;
                r_quot <= {r_quot[MBW-2:0], 1'b1};
            end else begin
                r_rem  <= w_t;
                r_quot <= {r_quot[MBW-2:0], 1'b0};
            end
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_quot;

endmodule
`default_nettype wire
